>>> rtl/core/iwt_pkg.sv
// Shared types and constants for the in-flight watermark table.
// Used by iwt_cell, iwt_chain and inflight_percentile_watermark_table.
package iwt_pkg;

  localparam int unsigned PercentScale = 100;
  localparam int unsigned StampW       = 32;
  localparam int unsigned IdW          = 64;
  localparam int unsigned BytesW       = 32;
  localparam int unsigned HeldW        = 40;
  localparam int unsigned CountOutW    = 9;
  // floor(x / 100) == (x * RecipMul) >> RecipShift for x below 2^30
  localparam int unsigned RecipShift   = 32;
  localparam logic [25:0] RecipMul     = 26'd42949673;
  localparam int unsigned ScaledW      = 33;

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_CONTAINS   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_UPDATE,
    S_RESULT
  } state_e;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_NEW,
    SEL_SHIFT
  } cell_sel_e;

  typedef enum logic {
    CFG_KEEP_PERCENT  = 1'b0,
    CFG_DELAY_SECONDS = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic probe;
    logic ins;
    logic del;
  } chain_ctrl_t;

endpackage

>>> rtl/core/iwt_cell.sv
// One cell of the sorted chain: holds an entry and its registered id match.
// Depends on iwt_pkg.
module iwt_cell #(
  parameter int unsigned CarryW = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  iwt_pkg::cell_sel_e         sel_i,
  input  logic                       probe_i,
  input  logic [iwt_pkg::IdW-1:0]    probe_id_i,
  input  logic [iwt_pkg::StampW-1:0] new_key_i,
  input  logic [CarryW-1:0]          new_carry_i,
  input  logic                       nb_valid_i,
  input  logic [iwt_pkg::IdW-1:0]    nb_id_i,
  input  logic [iwt_pkg::StampW-1:0] nb_key_i,
  input  logic [CarryW-1:0]          nb_carry_i,
  output logic                       valid_o,
  output logic [iwt_pkg::IdW-1:0]    id_o,
  output logic [iwt_pkg::StampW-1:0] key_o,
  output logic [CarryW-1:0]          carry_o,
  output logic                       hit_o
);

  logic                       valid_q, valid_d;
  logic                       hit_q, hit_d;
  logic [iwt_pkg::IdW-1:0]    id_q, id_d;
  logic [iwt_pkg::StampW-1:0] key_q, key_d;
  logic [CarryW-1:0]          carry_q, carry_d;

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    key_d   = key_q;
    carry_d = carry_q;
    case (sel_i)
      iwt_pkg::SEL_NEW: begin
        valid_d = 1'b1;
        id_d    = probe_id_i;
        key_d   = new_key_i;
        carry_d = new_carry_i;
      end
      iwt_pkg::SEL_SHIFT: begin
        valid_d = nb_valid_i;
        id_d    = nb_id_i;
        key_d   = nb_key_i;
        carry_d = nb_carry_i;
      end
      default: ;
    endcase
    hit_d = probe_i ? (valid_q && (id_q == probe_id_i)) : hit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    key_q   <= key_d;
    carry_q <= carry_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign key_o   = key_q;
  assign carry_o = carry_q;
  assign hit_o   = hit_q;

endmodule

>>> rtl/core/iwt_chain.sv
// Row of cells kept packed at the low end and sorted ascending by key.
// Depends on iwt_pkg and iwt_cell.
module iwt_chain #(
  parameter int unsigned Capacity = 256,
  parameter int unsigned CarryW   = 1
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  iwt_pkg::chain_ctrl_t                      ctrl_i,
  input  logic [iwt_pkg::IdW-1:0]                   id_i,
  input  logic [iwt_pkg::StampW-1:0]                key_i,
  input  logic [CarryW-1:0]                         carry_i,
  output logic [Capacity-1:0][iwt_pkg::StampW-1:0]  keys_o,
  output logic [CarryW-1:0]                         carry_o
);

  localparam int unsigned IdxW = $clog2(Capacity);

  logic [Capacity-1:0]                        valid;
  logic [Capacity-1:0]                        hit;
  logic [Capacity-1:0]                        gt;
  logic [Capacity-1:0][iwt_pkg::IdW-1:0]      ids;
  logic [Capacity-1:0][CarryW-1:0]            carries;
  logic [IdxW-1:0]                            del_pos;

  // position of the matching cell (hit is at most one-hot)
  always_comb begin
    del_pos = '0;
    carry_o = '0;
    for (int j = 0; j < Capacity; j++) begin
      if (hit[j]) begin
        del_pos = del_pos | IdxW'(j);
        carry_o = carry_o | carries[j];
      end
    end
  end

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    iwt_pkg::cell_sel_e        sel;
    logic                      nb_valid;
    logic [iwt_pkg::IdW-1:0]   nb_id;
    logic [iwt_pkg::StampW-1:0] nb_key;
    logic [CarryW-1:0]         nb_carry;
    logic                      left_gt;

    assign gt[i] = !valid[i] || (keys_o[i] > key_i);

    if (i == 0) begin : g_first
      assign left_gt = 1'b0;
    end else begin : g_rest
      assign left_gt = gt[i-1];
    end

    // insert pulls from the left, delete from the right
    always_comb begin
      nb_valid = 1'b0;
      nb_id    = '0;
      nb_key   = '0;
      nb_carry = '0;
      if (ctrl_i.ins) begin
        if (i > 0) begin
          nb_valid = valid[(i > 0) ? i-1 : 0];
          nb_id    = ids[(i > 0) ? i-1 : 0];
          nb_key   = keys_o[(i > 0) ? i-1 : 0];
          nb_carry = carries[(i > 0) ? i-1 : 0];
        end
      end else if (i < Capacity-1) begin
        nb_valid = valid[(i < Capacity-1) ? i+1 : i];
        nb_id    = ids[(i < Capacity-1) ? i+1 : i];
        nb_key   = keys_o[(i < Capacity-1) ? i+1 : i];
        nb_carry = carries[(i < Capacity-1) ? i+1 : i];
      end
    end

    always_comb begin
      sel = iwt_pkg::SEL_HOLD;
      if (ctrl_i.ins && gt[i]) begin
        sel = left_gt ? iwt_pkg::SEL_SHIFT : iwt_pkg::SEL_NEW;
      end else if (ctrl_i.del && (IdxW'(i) >= del_pos)) begin
        sel = iwt_pkg::SEL_SHIFT;
      end
    end

    iwt_cell #(
      .CarryW(CarryW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .sel_i      (sel),
      .probe_i    (ctrl_i.probe),
      .probe_id_i (id_i),
      .new_key_i  (key_i),
      .new_carry_i(carry_i),
      .nb_valid_i (nb_valid),
      .nb_id_i    (nb_id),
      .nb_key_i   (nb_key),
      .nb_carry_i (nb_carry),
      .valid_o    (valid[i]),
      .id_o       (ids[i]),
      .key_o      (keys_o[i]),
      .carry_o    (carries[i]),
      .hit_o      (hit[i])
    );
  end

endmodule

>>> rtl/core/inflight_percentile_watermark_table.sv
// In-flight entry table with a percentile watermark. Entries live in two rows
// of cells, one sorted by event stamp and one by system stamp, so the minima
// sit in cell 0 and the percentile stamp is read straight from its rank. Every
// transfer in gives one transfer out. After the accept, the result passes an id
// probe of all cells, one shift of the cell rows, then the rank read and
// watermark into the output register. The input is ready again in the cycle
// after that, so a new item is taken only once the last result is registered,
// and later while an earlier result waits in the output register. Writes to
// keep percent pass keep_q then scaled_q; delay writes act from delay_q.
module inflight_percentile_watermark_table #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [31:0]                       cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        operation_i,
  input  logic [iwt_pkg::IdW-1:0]           entry_id_i,
  input  logic [iwt_pkg::BytesW-1:0]        byte_size_i,
  input  logic [iwt_pkg::StampW-1:0]        system_stamp_i,
  input  logic [iwt_pkg::StampW-1:0]        event_stamp_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic [iwt_pkg::CountOutW-1:0]     entry_count_o,
  output logic [iwt_pkg::HeldW-1:0]         bytes_held_o,
  output logic                              min_system_valid_o,
  output logic [iwt_pkg::StampW-1:0]        min_system_stamp_o,
  output logic                              watermark_valid_o,
  output logic [iwt_pkg::StampW-1:0]        watermark_stamp_o
);

  localparam int unsigned IdxW  = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned ProdW = CntW + iwt_pkg::ScaledW;

  iwt_pkg::state_e state_q, state_d;
  iwt_pkg::chain_ctrl_t ctrl;

  logic [6:0]                   keep_q;
  logic [iwt_pkg::StampW-1:0]   delay_q;
  logic [iwt_pkg::ScaledW-1:0]  scaled_q;
  logic [6:0]                   keep_clamped;

  logic [1:0]                   op_q;
  logic [iwt_pkg::IdW-1:0]      id_q;
  logic [iwt_pkg::BytesW-1:0]   bytes_q;
  logic [iwt_pkg::StampW-1:0]   sys_q;
  logic [iwt_pkg::StampW-1:0]   ev_q;

  logic [CntW-1:0]              count_q, count_d;
  logic [iwt_pkg::HeldW-1:0]    held_q, held_d;
  logic [1:0]                   status_q, status_d;
  logic [ProdW-1:0]             prod_q, prod_d;

  logic [CAPACITY-1:0][iwt_pkg::StampW-1:0] ev_keys;
  logic [CAPACITY-1:0][iwt_pkg::StampW-1:0] sys_keys;
  logic [iwt_pkg::BytesW-1:0]   rem_bytes;
  logic                         found;
  logic                         full;
  logic                         do_ins, do_del;
  logic                         out_free;

  logic                         out_valid_q;
  logic [1:0]                   o_status_q;
  logic [CntW-1:0]              o_count_q;
  logic [iwt_pkg::HeldW-1:0]    o_held_q;
  logic                         o_msv_q, o_wmv_q;
  logic [iwt_pkg::StampW-1:0]   o_mss_q, o_wm_q;

  logic [CntW-1:0]              rank;
  logic                         nonempty, wm_ok;
  logic [iwt_pkg::StampW-1:0]   raw, pct, wm;
  logic [CntW+iwt_pkg::CountOutW-1:0] cnt_ext;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q  <= 7'(iwt_pkg::PercentScale);
      delay_q <= '0;
    end else if (cfg_we_i) begin
      unique case (iwt_pkg::cfg_idx_e'(cfg_idx_i))
        iwt_pkg::CFG_KEEP_PERCENT:  keep_q  <= cfg_wdata_i[6:0];
        iwt_pkg::CFG_DELAY_SECONDS: delay_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign keep_clamped = (keep_q > 7'(iwt_pkg::PercentScale)) ?
                        7'(iwt_pkg::PercentScale) : keep_q;

  // (100 - p) pre-scaled by the reciprocal of 100
  always_ff @(posedge clk_i) begin
    scaled_q <= iwt_pkg::ScaledW'((7'(iwt_pkg::PercentScale) - keep_clamped)
                                  * iwt_pkg::RecipMul);
  end

  iwt_chain #(
    .Capacity(CAPACITY),
    .CarryW  (iwt_pkg::BytesW)
  ) u_ev_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .id_i   (id_q),
    .key_i  (ev_q),
    .carry_i(bytes_q),
    .keys_o (ev_keys),
    .carry_o(rem_bytes)
  );

  // carries a single set bit, so its carry output is the match flag
  iwt_chain #(
    .Capacity(CAPACITY),
    .CarryW  (1)
  ) u_sys_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .id_i   (id_q),
    .key_i  (sys_q),
    .carry_i(1'b1),
    .keys_o (sys_keys),
    .carry_o(found)
  );

  assign full     = (count_q == CntW'(CAPACITY));
  assign do_ins   = (op_q == iwt_pkg::OP_REGISTER) && !found && !full;
  assign do_del   = (op_q == iwt_pkg::OP_UNREGISTER) && found;
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iwt_pkg::S_IDLE:   if (in_valid_i) state_d = iwt_pkg::S_PROBE;
      iwt_pkg::S_PROBE:  state_d = iwt_pkg::S_UPDATE;
      iwt_pkg::S_UPDATE: state_d = iwt_pkg::S_RESULT;
      iwt_pkg::S_RESULT: if (out_free) state_d = iwt_pkg::S_IDLE;
      default:           state_d = iwt_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    ctrl       = '0;
    unique case (state_q)
      iwt_pkg::S_IDLE:   in_ready_o = 1'b1;
      iwt_pkg::S_PROBE:  ctrl.probe = 1'b1;
      iwt_pkg::S_UPDATE: begin
        ctrl.ins = do_ins;
        ctrl.del = do_del;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iwt_pkg::S_IDLE;
      count_q <= '0;
      held_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q    <= operation_i;
      id_q    <= entry_id_i;
      bytes_q <= byte_size_i;
      sys_q   <= system_stamp_i;
      ev_q    <= event_stamp_i;
    end
    status_q <= status_d;
    prod_q   <= prod_d;
  end

  always_comb begin
    count_d  = count_q;
    held_d   = held_q;
    status_d = status_q;
    prod_d   = prod_q;
    if (state_q == iwt_pkg::S_UPDATE) begin
      if (do_ins) begin
        count_d = count_q + CntW'(1);
        held_d  = held_q + iwt_pkg::HeldW'(bytes_q);
      end else if (do_del) begin
        count_d = count_q - CntW'(1);
        held_d  = held_q - iwt_pkg::HeldW'(rem_bytes);
      end
      case (op_q)
        iwt_pkg::OP_REGISTER:
          status_d = found ? iwt_pkg::ST_MISS : (full ? iwt_pkg::ST_FULL : iwt_pkg::ST_OK);
        iwt_pkg::OP_UNREGISTER,
        iwt_pkg::OP_CONTAINS:
          status_d = found ? iwt_pkg::ST_OK : iwt_pkg::ST_MISS;
        default:
          status_d = iwt_pkg::ST_MISS;
      endcase
      prod_d = ProdW'(count_d) * ProdW'(scaled_q);
    end
  end

  // rank read and watermark
  assign rank     = prod_q[iwt_pkg::RecipShift +: CntW];
  assign nonempty = (count_q != '0);
  assign wm_ok    = nonempty && (rank < count_q);
  assign raw      = ev_keys[rank[IdxW-1:0]];
  assign pct      = (raw > delay_q) ? (raw - delay_q) : '0;
  assign wm       = (pct > ev_keys[0]) ? pct : ev_keys[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == iwt_pkg::S_RESULT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == iwt_pkg::S_RESULT) && out_free) begin
      o_status_q <= status_q;
      o_count_q  <= count_q;
      o_held_q   <= held_q;
      o_msv_q    <= nonempty;
      o_mss_q    <= nonempty ? sys_keys[0] : '0;
      o_wmv_q    <= wm_ok;
      o_wm_q     <= wm_ok ? wm : '0;
    end
  end

  assign cnt_ext            = {{iwt_pkg::CountOutW{1'b0}}, o_count_q};
  assign out_valid_o        = out_valid_q;
  assign status_o           = o_status_q;
  assign entry_count_o      = cnt_ext[iwt_pkg::CountOutW-1:0];
  assign bytes_held_o       = o_held_q;
  assign min_system_valid_o = o_msv_q;
  assign min_system_stamp_o = o_mss_q;
  assign watermark_valid_o  = o_wmv_q;
  assign watermark_stamp_o  = o_wm_q;

endmodule

>>> tb/inflight_percentile_watermark_table_test.sv
// Self-checking testbench for inflight_percentile_watermark_table.
// Needs iwt_pkg and the block's RTL; a scoreboard class predicts each result
// from its own copy of the entry table and configuration.
`timescale 1ns / 1ps

module inflight_percentile_watermark_table_test;
  import iwt_pkg::*;

  localparam int unsigned Slots     = 256;
  localparam logic [1:0]  OpUnused  = 2'd3;
  localparam int unsigned DrainWait = 10;

  typedef struct packed {
    logic [1:0]           status;
    logic [CountOutW-1:0] count;
    logic [HeldW-1:0]     bytes;
    logic                 sys_valid;
    logic [StampW-1:0]    sys_stamp;
    logic                 wm_valid;
    logic [StampW-1:0]    wm_stamp;
  } table_result_t;

  class watermark_scoreboard;
    bit                table_used [Slots];
    logic [IdW-1:0]    table_id   [Slots];
    logic [BytesW-1:0] table_bytes[Slots];
    logic [StampW-1:0] table_sys  [Slots];
    logic [StampW-1:0] table_ev   [Slots];
    int unsigned       held_n;
    logic [HeldW-1:0]  held_sum;
    logic [6:0]        keep_pct;
    logic [31:0]       delay_s;
    table_result_t     awaited[$];
    int unsigned       errors;

    function void clear();
      foreach (table_used[i]) table_used[i] = 1'b0;
      held_n = 0; held_sum = '0; keep_pct = 7'd100; delay_s = '0; errors = 0;
    endfunction

    function int lookup(logic [IdW-1:0] id);
      for (int i = 0; i < Slots; i++)
        if (table_used[i] && table_id[i] == id) return i;
      return -1;
    endfunction

    function logic [IdW-1:0] any_held();
      int idx[$];
      for (int i = 0; i < Slots; i++) if (table_used[i]) idx = {idx, i};
      if (idx.size() == 0) return {$urandom, $urandom};
      return table_id[idx[$urandom_range(0, idx.size() - 1)]];
    endfunction

    function void note_transfer(logic [1:0] op, logic [IdW-1:0] id, logic [BytesW-1:0] b,
                                logic [StampW-1:0] sys, logic [StampW-1:0] ev);
      table_result_t r;
      logic [StampW-1:0] stamps[$];
      int s, free_at;
      longint unsigned p, k, raw, pct, min_ev;
      r = '0;
      r.status = ST_MISS;
      s = lookup(id);
      case (op)
        OP_REGISTER: begin
          free_at = -1;
          for (int i = Slots - 1; i >= 0; i--) if (!table_used[i]) free_at = i;
          if (s >= 0) r.status = ST_MISS;
          else if (free_at < 0) r.status = ST_FULL;
          else begin
            table_used[free_at] = 1'b1; table_id[free_at] = id; table_bytes[free_at] = b;
            table_sys[free_at] = sys; table_ev[free_at] = ev;
            held_n++; held_sum += b; r.status = ST_OK;
          end
        end
        OP_UNREGISTER: if (s >= 0) begin
          table_used[s] = 1'b0; held_n--; held_sum -= table_bytes[s]; r.status = ST_OK;
        end
        OP_CONTAINS: r.status = (s >= 0) ? ST_OK : ST_MISS;
        default: r.status = ST_MISS;
      endcase
      r.count = held_n[CountOutW-1:0];
      r.bytes = held_sum;
      if (held_n > 0) begin
        r.sys_stamp = '1;
        for (int i = 0; i < Slots; i++) if (table_used[i]) begin
          stamps = {stamps, table_ev[i]};
          if (table_sys[i] < r.sys_stamp) r.sys_stamp = table_sys[i];
        end
        stamps.sort();
        r.sys_valid = 1'b1;
        p = (keep_pct > PercentScale) ? PercentScale : keep_pct;
        k = held_n * (PercentScale - p) / PercentScale;
        if (k < held_n) begin
          raw = stamps[k];
          min_ev = stamps[0];
          pct = ((raw > delay_s) ? raw : delay_s) - delay_s;
          r.wm_valid = 1'b1;
          r.wm_stamp = (pct > min_ev) ? pct : min_ev;
        end
      end
      awaited = {awaited, r};
    endfunction

    function void check_result(table_result_t got);
      table_result_t exp;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing awaited: %p", $realtime, got);
        errors++;
        return;
      end
      exp = awaited.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status exp %0d got %0d", $realtime, exp.status, got.status); errors++;
      end
      if (got.count !== exp.count) begin
        $display("%0t: count exp %0d got %0d", $realtime, exp.count, got.count); errors++;
      end
      if (got.bytes !== exp.bytes) begin
        $display("%0t: bytes exp %h got %h", $realtime, exp.bytes, got.bytes); errors++;
      end
      if (got.sys_valid !== exp.sys_valid) begin
        $display("%0t: min sys valid exp %b got %b", $realtime, exp.sys_valid, got.sys_valid);
        errors++;
      end
      if (got.sys_stamp !== exp.sys_stamp) begin
        $display("%0t: min sys exp %h got %h", $realtime, exp.sys_stamp, got.sys_stamp);
        errors++;
      end
      if (got.wm_valid !== exp.wm_valid) begin
        $display("%0t: wm valid exp %b got %b", $realtime, exp.wm_valid, got.wm_valid);
        errors++;
      end
      if (got.wm_stamp !== exp.wm_stamp) begin
        $display("%0t: wm exp %h got %h", $realtime, exp.wm_stamp, got.wm_stamp); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i, cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [1:0] operation_i, status_o;
  logic [IdW-1:0] entry_id_i;
  logic [BytesW-1:0] byte_size_i;
  logic [StampW-1:0] system_stamp_i, event_stamp_i;
  logic [CountOutW-1:0] entry_count_o;
  logic [HeldW-1:0] bytes_held_o;
  logic min_system_valid_o, watermark_valid_o;
  logic [StampW-1:0] min_system_stamp_o, watermark_stamp_o;

  watermark_scoreboard sb;
  bit gaps_on;
  bit hold_off_req;
  logic [IdW-1:0] id_pool[64];

  inflight_percentile_watermark_table dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("inflight_percentile_watermark_table_test: done, errors");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall, hold;
    stall = 0; hold = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_result({status_o, entry_count_o, bytes_held_o, min_system_valid_o,
                         min_system_stamp_o, watermark_valid_o, watermark_stamp_o});
      if (hold_off_req && hold == 0) begin
        hold = 400; hold_off_req = 1'b0;
      end
      if (hold > 0) begin
        hold--; out_ready_i <= 1'b0;
      end else if (stall > 0) begin
        stall--; out_ready_i <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 12) - 1; out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_item(logic [1:0] op, logic [IdW-1:0] id, logic [BytesW-1:0] b,
                           logic [StampW-1:0] sys, logic [StampW-1:0] ev);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op; entry_id_i <= id; byte_size_i <= b;
    system_stamp_i <= sys; event_stamp_i <= ev;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_transfer(op, id, b, sys, ev);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [31:0] val);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_KEEP_PERCENT) sb.keep_pct = val[6:0];
    else sb.delay_s = val;
    @(posedge clk_i);
  endtask

  function automatic logic [StampW-1:0] rand_stamp();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 40);
      2: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: return 32'd1000 + $urandom_range(0, 200);
    endcase
  endfunction

  task automatic random_item();
    logic [1:0] op;
    logic [IdW-1:0] id;
    int unsigned r;
    r = $urandom_range(0, 99);
    op = (r < 45) ? OP_REGISTER : (r < 75) ? OP_UNREGISTER : (r < 95) ? OP_CONTAINS : OpUnused;
    r = $urandom_range(0, 9);
    if (r < 5 && op != OP_REGISTER) id = sb.any_held();
    else if (r < 2) id = sb.any_held();
    else if (r < 8) id = id_pool[$urandom_range(0, 63)];
    else id = {$urandom, $urandom};
    send_item(op, id, $urandom, rand_stamp(), rand_stamp());
  endtask

  initial begin
    logic [31:0] pct_set[10];
    logic [31:0] delay_set[10];
    sb = new();
    sb.clear();
    foreach (id_pool[i]) id_pool[i] = {$urandom, $urandom};
    rst_ni = 1'b0; gaps_on = 1'b1; hold_off_req = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_KEEP_PERCENT; cfg_wdata_i = '0;
    in_valid_i = 1'b0; operation_i = OP_CONTAINS; entry_id_i = '0;
    byte_size_i = '0; system_stamp_i = '0; event_stamp_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, duplicates, absent ids, unused op
    send_item(OP_CONTAINS, '0, '0, '0, '0);
    send_item(OP_UNREGISTER, '1, '0, '0, '0);
    send_item(OP_REGISTER, '0, '1, '1, '1);
    send_item(OP_REGISTER, '1, '0, '0, '0);
    send_item(OP_REGISTER, '0, 32'd5, 32'd5, 32'd5);
    send_item(OP_CONTAINS, '1, '0, '0, '0);
    send_item(OP_REGISTER, 64'h5555_5555_5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_item(OP_REGISTER, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(OpUnused, '0, '1, '1, '1);
    send_item(OP_UNREGISTER, '0, '0, '0, '0);
    send_item(OP_UNREGISTER, '0, '0, '0, '0);
    send_item(OP_CONTAINS, 64'h5555_5555_5555_5555, '1, '1, '1);

    pct_set   = '{32'd0, 32'd50, 32'd127, 32'd1, 32'd99, 32'd100, 32'd75, 32'd101,
                  32'd10, 32'd90};
    delay_set = '{32'd0, 32'd20, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd100, 32'h8000_0000,
                  32'd5, 32'd0, 32'd1};
    for (int ph = 0; ph < 10; ph++) begin
      write_cfg(CFG_KEEP_PERCENT, pct_set[ph]);
      write_cfg(CFG_DELAY_SECONDS, delay_set[ph]);
      if (ph == 8) gaps_on = 1'b0;
      if (ph == 2) hold_off_req = 1'b1;
      if (ph == 4) begin
        // fill to capacity with largest sizes (the 40-bit byte total cannot wrap), then drain
        for (int i = 0; i < Slots + 4; i++)
          send_item(OP_REGISTER, {$urandom, $urandom}, '1, rand_stamp(), rand_stamp());
        for (int i = 0; i < Slots; i++) send_item(OP_UNREGISTER, sb.any_held(), '0, '0, '0);
      end
      repeat (100) random_item();
    end

    in_valid_i <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("inflight_percentile_watermark_table_test: done, clean");
    else
      $display("inflight_percentile_watermark_table_test: done, errors");
    $finish;
  end

endmodule

>>> files.f
rtl/core/iwt_pkg.sv
rtl/core/iwt_cell.sv
rtl/core/iwt_chain.sv
rtl/core/inflight_percentile_watermark_table.sv
tb/inflight_percentile_watermark_table_test.sv
